// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH   = 16;
  localparam int DEFAULT_PRIORITY_BITS = 8;

  localparam int PRIO_PORT_BITS = 8;
  localparam int NAME_BITS      = 16;
  localparam int DISEASE_BITS   = 4;
  localparam int AGE_BITS       = 7;
  localparam int RECORD_BITS    = NAME_BITS + DISEASE_BITS + 1 + AGE_BITS;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [AGE_BITS-1:0]     age;
    logic                    is_male;
    logic [DISEASE_BITS-1:0] disease_code;
    logic [NAME_BITS-1:0]    name_handle;
  } record_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ===== rtl/stable_priority_queue.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Beat contents
// in       input      in_valid / in_ready      kind, priority_req, record fields
// out      output     out_valid / out_ready    status, removed record, occupancy
//
// The row of cells updates in parallel, so a new beat is
// accepted on every cycle in which the output register is empty or being drained.
// The result of a beat appears in the output register on the cycle after acceptance.
// Reset empties the queue at once; no clearing pass is needed.
// While out_valid is high and out_ready is low, in_ready is held low.

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS,
  localparam int CW           = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [PRIO_PORT_BITS-1:0] priority_req,
  input  logic [NAME_BITS-1:0]      name_handle,
  input  logic [DISEASE_BITS-1:0]   disease_code,
  input  logic                      is_male,
  input  logic [AGE_BITS-1:0]       age,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [NAME_BITS-1:0]      out_name_handle,
  output logic [DISEASE_BITS-1:0]   out_disease_code,
  output logic                      out_is_male,
  output logic [AGE_BITS-1:0]       out_age,
  output logic [PRIO_PORT_BITS-1:0] out_priority,
  output logic [CW-1:0]             occupancy
);

  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  cell_ctrl_t                ctrl;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [PRIORITY_BITS-1:0]  prio_in;
  record_t                   rec_in;
  logic [PRIO_PORT_BITS-1:0] head_prio_port;

  logic [QUEUE_DEPTH-1:0]    valid_vec;
  logic [QUEUE_DEPTH-1:0]    cond_vec;
  logic [PRIORITY_BITS-1:0]  prio_arr [QUEUE_DEPTH];
  record_t                   rec_arr  [QUEUE_DEPTH];

  status_t                   res_status;
  record_t                   res_rec;
  logic [PRIO_PORT_BITS-1:0] res_prio;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == CW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  assign ctrl.insert = accept && (kind_t'(kind) == KIND_INSERT) && !is_full;
  assign ctrl.remove = accept && (kind_t'(kind) == KIND_REMOVE) && !is_empty;

  assign rec_in.name_handle  = name_handle;
  assign rec_in.disease_code = disease_code;
  assign rec_in.is_male      = is_male;
  assign rec_in.age          = age;

  generate
    if (PRIORITY_BITS >= PRIO_PORT_BITS) begin : g_prio_wide
      assign prio_in        = PRIORITY_BITS'(priority_req);
      assign head_prio_port = prio_arr[0][PRIO_PORT_BITS-1:0];
    end else begin : g_prio_narrow
      assign prio_in        = priority_req[PRIORITY_BITS-1:0];
      assign head_prio_port = PRIO_PORT_BITS'(prio_arr[0]);
    end
  endgenerate

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                     l_cond;
      logic                     l_valid;
      logic [PRIORITY_BITS-1:0] l_prio;
      record_t                  l_rec;
      logic                     r_valid;
      logic [PRIORITY_BITS-1:0] r_prio;
      record_t                  r_rec;

      if (i == 0) begin : g_head
        assign l_cond  = 1'b0;
        assign l_valid = 1'b0;
        assign l_prio  = '0;
        assign l_rec   = '0;
      end else begin : g_body
        assign l_cond  = cond_vec[i-1];
        assign l_valid = valid_vec[i-1];
        assign l_prio  = prio_arr[i-1];
        assign l_rec   = rec_arr[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_prio  = '0;
        assign r_rec   = '0;
      end else begin : g_inner
        assign r_valid = valid_vec[i+1];
        assign r_prio  = prio_arr[i+1];
        assign r_rec   = rec_arr[i+1];
      end

      spq_cell #(
        .PRIORITY_BITS(PRIORITY_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .new_prio   (prio_in),
        .new_rec    (rec_in),
        .left_cond  (l_cond),
        .left_valid (l_valid),
        .left_prio  (l_prio),
        .left_rec   (l_rec),
        .right_valid(r_valid),
        .right_prio (r_prio),
        .right_rec  (r_rec),
        .cond       (cond_vec[i]),
        .valid      (valid_vec[i]),
        .prio       (prio_arr[i]),
        .rec        (rec_arr[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CW'(1);
    end else if (ctrl.remove) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    res_rec  = '0;
    res_prio = '0;
    case (kind_t'(kind))
      KIND_INSERT: begin
        res_status = is_full ? ST_FULL : ST_INSERTED;
      end
      KIND_REMOVE: begin
        if (is_empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_status = ST_REMOVED;
          res_rec    = rec_arr[0];
          res_prio   = head_prio_port;
        end
      end
      default: begin
        res_status = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status           <= res_status;
      out_name_handle  <= res_rec.name_handle;
      out_disease_code <= res_rec.disease_code;
      out_is_male      <= res_rec.is_male;
      out_age          <= res_rec.age;
      out_priority     <= res_prio;
      occupancy        <= count_next;
    end
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("Stored count disagrees with occupied cells.");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> count == $past(count) + CW'(1))
    else $error("Accepted insert did not grow the queue.");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.remove |=> count == $past(count) - CW'(1))
    else $error("Accepted remove did not shrink the queue.");

  generate
    for (i = 1; i < QUEUE_DEPTH; i++) begin : g_order_chk
      a_sorted: assert property (@(posedge clk) disable iff (rst)
        valid_vec[i] |-> (valid_vec[i-1] && (prio_arr[i] <= prio_arr[i-1])))
        else $error("Cells are not packed in non-increasing priority order.");
    end
  endgenerate

endmodule

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
#(
  parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  record_t                  new_rec,
  input  logic                     left_cond,
  input  logic                     left_valid,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  record_t                  left_rec,
  input  logic                     right_valid,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  record_t                  right_rec,
  output logic                     cond,
  output logic                     valid,
  output logic [PRIORITY_BITS-1:0] prio,
  output record_t                  rec
);

  logic                     valid_next;
  logic [PRIORITY_BITS-1:0] prio_next;
  record_t                  rec_next;

  // The new record belongs at or above this slot once the slot is empty or weaker.
  assign cond = !valid || (prio < new_prio);

  always_comb begin
    valid_next = valid;
    prio_next  = prio;
    rec_next   = rec;
    if (ctrl.insert) begin
      if (left_cond) begin
        valid_next = left_valid;
        prio_next  = left_prio;
        rec_next   = left_rec;
      end else if (cond) begin
        valid_next = 1'b1;
        prio_next  = new_prio;
        rec_next   = new_rec;
      end
    end else if (ctrl.remove) begin
      valid_next = right_valid;
      prio_next  = right_prio;
      rec_next   = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    rec  <= rec_next;
  end

endmodule

// ===== tb/tb_stable_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
  localparam int OCC_BITS    = $clog2(DEPTH + 1);
  localparam int RANDOM_BEATS = 600;
  localparam int CALM_BEATS  = 100;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    kind_t                   op;
    logic [PRIO_PORT_BITS-1:0] prio;
    record_t                 rec;
    bit                      typed;
    status_t                 st;
    logic [OCC_BITS-1:0]     occ;
  } beat_row_t;

  typedef struct {
    status_t                 st;
    record_t                 rec;
    logic [PRIO_PORT_BITS-1:0] prio;
    logic [OCC_BITS-1:0]     occ;
  } triage_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      kind = KIND_INSERT;
  logic [PRIO_PORT_BITS-1:0] priority_req = '0;
  logic [NAME_BITS-1:0]      name_handle = '0;
  logic [DISEASE_BITS-1:0]   disease_code = '0;
  logic                      is_male = 1'b0;
  logic [AGE_BITS-1:0]       age = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                status;
  logic [NAME_BITS-1:0]      out_name_handle;
  logic [DISEASE_BITS-1:0]   out_disease_code;
  logic                      out_is_male;
  logic [AGE_BITS-1:0]       out_age;
  logic [PRIO_PORT_BITS-1:0] out_priority;
  logic [OCC_BITS-1:0]       occupancy;

  logic [PRIO_PORT_BITS-1:0] ward_prio [DEPTH];
  record_t                   ward_rec [DEPTH];
  int                        ward_count = 0;
  triage_result_t            pending_results [$];
  beat_row_t                 directed_rows [$];
  int                        mismatches = 0;
  int                        cycle_count = 0;
  int                        drain_stall_pct = 0;
  int                        stall_left = 0;

  stable_priority_queue u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .priority_req     (priority_req),
    .name_handle      (name_handle),
    .disease_code     (disease_code),
    .is_male          (is_male),
    .age              (age),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .out_name_handle  (out_name_handle),
    .out_disease_code (out_disease_code),
    .out_is_male      (out_is_male),
    .out_age          (out_age),
    .out_priority     (out_priority),
    .occupancy        (occupancy)
  );

  always #4 clk = ~clk;

  function automatic beat_row_t mk_row(kind_t op, int prio, int name, int dis, int male,
                                       int yrs, bit typed, status_t st, int occ);
    beat_row_t b;
    b.op               = op;
    b.prio             = PRIO_PORT_BITS'(prio);
    b.rec.name_handle  = NAME_BITS'(name);
    b.rec.disease_code = DISEASE_BITS'(dis);
    b.rec.is_male      = male[0];
    b.rec.age          = AGE_BITS'(yrs);
    b.typed            = typed;
    b.st               = st;
    b.occ              = OCC_BITS'(occ);
    return b;
  endfunction

  // Sorted insert behind every record of greater or equal priority; remove takes slot 0.
  task automatic triage_step(input beat_row_t b, output triage_result_t res);
    int pos;
    int i;
    res.rec  = '0;
    res.prio = '0;
    if (b.op == KIND_INSERT) begin
      if (ward_count >= DEPTH) begin
        res.st = ST_FULL;
      end else begin
        pos = 0;
        while (pos < ward_count && ward_prio[pos] >= b.prio) pos++;
        for (i = ward_count; i > pos; i--) begin
          ward_prio[i] = ward_prio[i-1];
          ward_rec[i]  = ward_rec[i-1];
        end
        ward_prio[pos] = b.prio;
        ward_rec[pos]  = b.rec;
        ward_count++;
        res.st = ST_INSERTED;
      end
    end else begin
      if (ward_count == 0) begin
        res.st = ST_EMPTY;
      end else begin
        res.rec  = ward_rec[0];
        res.prio = ward_prio[0];
        for (i = 0; i + 1 < ward_count; i++) begin
          ward_prio[i] = ward_prio[i+1];
          ward_rec[i]  = ward_rec[i+1];
        end
        ward_count--;
        res.st = ST_REMOVED;
      end
    end
    res.occ = OCC_BITS'(ward_count);
  endtask

  task automatic send_beat(input beat_row_t b);
    triage_result_t res;
    bit taken;
    in_valid     <= 1'b1;
    kind         <= b.op;
    priority_req <= b.prio;
    name_handle  <= b.rec.name_handle;
    disease_code <= b.rec.disease_code;
    is_male      <= b.rec.is_male;
    age          <= b.rec.age;
    do begin
      @(negedge clk);
      taken = in_valid && in_ready;
      @(posedge clk);
    end while (!taken);
    triage_step(b, res);
    if (b.typed) begin
      res.st   = b.st;
      res.rec  = '0;
      res.prio = '0;
      res.occ  = b.occ;
    end
    pending_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if ($urandom_range(0, 99) < drain_stall_pct) begin
      stall_left <= $urandom_range(1, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin : result_check
    triage_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, status %0h", $time, status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.st), 32'(status));
        check_field("out_name_handle", 32'(want.rec.name_handle), 32'(out_name_handle));
        check_field("out_disease_code", 32'(want.rec.disease_code), 32'(out_disease_code));
        check_field("out_is_male", 32'(want.rec.is_male), 32'(out_is_male));
        check_field("out_age", 32'(want.rec.age), 32'(out_age));
        check_field("out_priority", 32'(want.prio), 32'(out_priority));
        check_field("occupancy", 32'(want.occ), 32'(occupancy));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stable_priority_queue: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    beat_row_t b;
    int n;
    int insert_pct;
    int feed_idle_pct;
    int r;

    directed_rows.push_back(mk_row(KIND_REMOVE, 8'h5a, 16'h1111, 4'h3, 1, 7'd40, 1, ST_EMPTY, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 0, 0, 0, 0, 0, 1, ST_INSERTED, 1));
    directed_rows.push_back(mk_row(KIND_INSERT, 255, 16'hffff, 4'hf, 1, 7'h7f, 1, ST_INSERTED, 2));
    directed_rows.push_back(mk_row(KIND_INSERT, 255, 16'h1234, 4'h5, 0, 7'd33, 1, ST_INSERTED, 3));
    directed_rows.push_back(mk_row(KIND_INSERT, 0, 16'h0f0f, 4'ha, 1, 7'd1, 1, ST_INSERTED, 4));
    directed_rows.push_back(mk_row(KIND_INSERT, 128, 16'h8000, 4'h8, 0, 7'd64, 1, ST_INSERTED, 5));
    directed_rows.push_back(mk_row(KIND_INSERT, 128, 16'h0001, 4'h1, 1, 7'd2, 1, ST_INSERTED, 6));
    directed_rows.push_back(mk_row(KIND_INSERT, 128, 16'h5555, 4'h6, 0, 7'd85, 1, ST_INSERTED, 7));
    directed_rows.push_back(mk_row(KIND_INSERT, 1, 16'haaaa, 4'h9, 1, 7'd42, 1, ST_INSERTED, 8));
    directed_rows.push_back(mk_row(KIND_INSERT, 254, 16'h7fff, 4'h7, 0, 7'd126, 1, ST_INSERTED, 9));
    directed_rows.push_back(mk_row(KIND_INSERT, 64, 16'hc3c3, 4'hc, 1, 7'd17, 1, ST_INSERTED, 10));
    directed_rows.push_back(mk_row(KIND_INSERT, 64, 16'h3c3c, 4'h3, 0, 7'd99, 1, ST_INSERTED, 11));
    directed_rows.push_back(mk_row(KIND_INSERT, 255, 16'hbeef, 4'hb, 1, 7'd70, 1, ST_INSERTED, 12));
    directed_rows.push_back(mk_row(KIND_INSERT, 0, 16'hfffe, 4'he, 0, 7'd5, 1, ST_INSERTED, 13));
    directed_rows.push_back(mk_row(KIND_INSERT, 200, 16'h0100, 4'h2, 1, 7'd88, 1, ST_INSERTED, 14));
    directed_rows.push_back(mk_row(KIND_INSERT, 7, 16'h4242, 4'h4, 0, 7'd21, 1, ST_INSERTED, 15));
    directed_rows.push_back(mk_row(KIND_INSERT, 128, 16'h9999, 4'hd, 1, 7'd50, 1, ST_INSERTED, 16));
    directed_rows.push_back(mk_row(KIND_INSERT, 255, 16'hdead, 4'hf, 1, 7'h7f, 1, ST_FULL, 16));
    directed_rows.push_back(mk_row(KIND_REMOVE, 0, 0, 0, 0, 0, 0, ST_REMOVED, 0));
    directed_rows.push_back(mk_row(KIND_REMOVE, 0, 0, 0, 0, 0, 0, ST_REMOVED, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 255, 16'h2468, 4'h0, 0, 7'd60, 0, ST_INSERTED, 0));
    directed_rows.push_back(mk_row(KIND_REMOVE, 0, 0, 0, 0, 0, 0, ST_REMOVED, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    drain_stall_pct <= 20;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i]);
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end

    insert_pct    = 50;
    feed_idle_pct = 20;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      // Alternate filling, draining and balanced stretches so both full and empty are reached.
      if (n % 40 == 0 && n < RANDOM_BEATS - CALM_BEATS) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
        feed_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
        drain_stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : 25;
      end
      if (n == RANDOM_BEATS - CALM_BEATS) begin
        feed_idle_pct = 0;
        drain_stall_pct <= 0;
      end
      if (n >= RANDOM_BEATS - CALM_BEATS) feed_idle_pct = 0;

      b = mk_row(KIND_INSERT, 0, $urandom, $urandom, $urandom, $urandom, 0, ST_INSERTED, 0);
      if ($urandom_range(0, 99) >= insert_pct) b.op = KIND_REMOVE;
      r = $urandom_range(0, 9);
      if (r < 6) b.prio = PRIO_PORT_BITS'($urandom_range(0, 3));
      else if (r < 8) b.prio = PRIO_PORT_BITS'($urandom);
      else b.prio = (r == 8) ? 8'h00 : 8'hff;
      send_beat(b);

      if ($urandom_range(0, 99) < feed_idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("stable_priority_queue: match");
    end else begin
      $display("stable_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
tb/tb_stable_priority_queue.sv
